// File: design/npd_pkg.sv
// shared types and constants of the nearest point distance block
package npd_pkg;

    localparam int DIST_W = 17;
    localparam int SQ_W   = 33;
    localparam int BEST_W = 34;
    localparam int RAD_W  = 34;
    localparam int REM_W  = 20;
    localparam int ROOT_W = 17;
    localparam int LIM_W  = 17;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_stage_t;

endpackage

// File: design/nearest_point_distance.sv
// top level of the nearest point distance block
//
// input items arrive on the s_ stream: tuser is the mode, 0 loads one point
// into the table at point_index, 1 is a query with the given coordinates.
// a load gives no result. a query scans table entries
// 0 .. point_count-1 (point_count clamped to MAX_POINTS), one ram read a cycle,
// through a three stage squared distance pipeline and a running minimum, then
// passes the minimum through a chain of 17 square root cells, one digit each.
// with point_count zero the result item on the m_ stream has tuser (table_empty)
// set. point_count is written over the apb port at address 0; the user must do
// this only while the block idles, the block itself does not enforce it. after
// reset point_count is zero and the table contents are undefined; every entry a
// query scans must have been loaded first. the result waits in an output
// register while m_tready is low; loads are still taken then, and a finished
// query holds until the output register is free.
module nearest_point_distance #(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // apb configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [npd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [npd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [npd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fields from bit 0: point_index, coord_x, coord_y
    input  logic [((npd_pkg::INDEX_W + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // fields from bit 0: mode
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fields from bit 0: nearest_distance, nearest_squared
    output logic [55:0]                        m_tdata,
    // fields from bit 0: table_empty
    output logic                               m_tuser
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int IXW   = (AW > npd_pkg::INDEX_W) ? AW : npd_pkg::INDEX_W;
    localparam int OUT_W = npd_pkg::DIST_W + npd_pkg::SQ_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_ROOT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [npd_pkg::COUNT_W-1:0] point_count_reg;

    logic [npd_pkg::INDEX_W-1:0]   in_index;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic                          in_accept;
    logic                          load_ok;
    logic [IXW-1:0]                index_ext;
    logic [CW-1:0]                 count_eff;

    logic signed [COORD_WIDTH-1:0] qx_reg;
    logic signed [COORD_WIDTH-1:0] qy_reg;
    logic [CW-1:0]                 n_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          rd_v_reg;
    logic                          rd_en;
    logic                          scan_last;

    logic [2*COORD_WIDTH-1:0]      ram_rdata;

    logic                          dist_busy;
    logic                          dist_valid;
    logic [npd_pkg::BEST_W-1:0]    dist_sq;

    logic [npd_pkg::BEST_W-1:0]    best_reg;
    logic                          empty_reg;
    logic [npd_pkg::ROOT_W-1:0]    root_reg;
    logic                          drained;
    logic                          sqrt_start;

    npd_pkg::sqrt_stage_t          chain [npd_pkg::ROOT_W+1];

    logic                          out_load;
    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;
    logic                          out_empty_reg;
    logic [npd_pkg::SQ_W-1:0]      sq_sat;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == npd_pkg::REG_POINT_COUNT)
        begin
            point_count_reg <= pwdata[npd_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            npd_pkg::REG_POINT_COUNT: prdata = npd_pkg::APB_DATA_W'(point_count_reg);
            default:                  prdata = '0;
        endcase
    end

    // input unpacking
    assign in_index  = s_tdata[npd_pkg::INDEX_W-1:0];
    assign in_x      = s_tdata[npd_pkg::INDEX_W +: COORD_WIDTH];
    assign in_y      = s_tdata[npd_pkg::INDEX_W + COORD_WIDTH +: COORD_WIDTH];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign index_ext = IXW'(in_index);
    assign load_ok   = in_accept && (s_tuser == npd_pkg::MODE_LOAD)
                       && (32'(in_index) < 32'(MAX_POINTS));
    assign count_eff = (32'(point_count_reg) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                                 : CW'(point_count_reg);

    // scan control
    assign rd_en     = (state_reg == ST_SCAN);
    assign scan_last = (cnt_reg == n_reg - CW'(1));
    assign drained   = !rd_v_reg && !dist_busy;
    assign sqrt_start = (state_reg == ST_DRAIN) && drained;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && s_tuser == npd_pkg::MODE_QUERY)
                begin
                    state_next = (count_eff == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drained)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (chain[npd_pkg::ROOT_W].valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && s_tuser == npd_pkg::MODE_QUERY)
        begin
            qx_reg    <= in_x;
            qy_reg    <= in_y;
            n_reg     <= count_eff;
            cnt_reg   <= '0;
            empty_reg <= (count_eff == '0);
            best_reg  <= (count_eff == '0) ? '0 : '1;
            root_reg  <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (dist_valid && dist_sq < best_reg)
            begin
                best_reg <= dist_sq;
            end
            if (state_reg == ST_ROOT && chain[npd_pkg::ROOT_W].valid)
            begin
                root_reg <= chain[npd_pkg::ROOT_W].root;
            end
        end
    end

    npd_ram #(
        .WIDTH (2 * COORD_WIDTH),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (load_ok),
        .waddr (index_ext[AW-1:0]),
        .wdata ({in_y, in_x}),
        .re    (rd_en),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    npd_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_v_reg),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .px        (ram_rdata[COORD_WIDTH-1:0]),
        .py        (ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .busy      (dist_busy),
        .out_valid (dist_valid),
        .out_sq    (dist_sq)
    );

    // square root chain
    assign chain[0].valid = sqrt_start;
    assign chain[0].rad   = best_reg;
    assign chain[0].rem   = '0;
    assign chain[0].root  = '0;

    for (genvar k = 0; k < npd_pkg::ROOT_W; k++)
    begin : g_sqrt
        npd_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[k]),
            .stage_out (chain[k+1])
        );
    end

    // output register
    assign sq_sat = best_reg[npd_pkg::BEST_W-1] ? '1 : best_reg[npd_pkg::SQ_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg  <= {sq_sat, root_reg};
            out_empty_reg <= empty_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 56'(out_data_reg);
    assign m_tuser  = out_empty_reg;

endmodule

// File: design/npd_ram.sv
// generic single write port, single read port ram with registered read
module npd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/npd_dist.sv
// pipelined squared distance unit, clamped to the width the root needs
module npd_dist #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [COORD_WIDTH-1:0]     qx,
    input  logic signed [COORD_WIDTH-1:0]     qy,
    input  logic signed [COORD_WIDTH-1:0]     px,
    input  logic signed [COORD_WIDTH-1:0]     py,
    output logic                              busy,
    output logic                              out_valid,
    output logic [npd_pkg::BEST_W-1:0]        out_sq
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int EXT_W = (DW > npd_pkg::LIM_W) ? DW : npd_pkg::LIM_W + 1;
    localparam int PW    = 2 * npd_pkg::LIM_W;

    logic signed [DW-1:0] diff_x;
    logic signed [DW-1:0] diff_y;
    logic [DW-1:0]        abs_x;
    logic [DW-1:0]        abs_y;

    logic                 va_reg;
    logic [DW-1:0]        dx_reg;
    logic [DW-1:0]        dy_reg;

    logic [EXT_W-1:0]     dx_ext;
    logic [EXT_W-1:0]     dy_ext;
    logic                 ovf_next;
    logic [PW-1:0]        sqx_next;
    logic [PW-1:0]        sqy_next;

    logic                 vb_reg;
    logic                 ovf_reg;
    logic [PW-1:0]        sqx_reg;
    logic [PW-1:0]        sqy_reg;

    logic [PW:0]          sum;
    logic [npd_pkg::BEST_W-1:0] sq_next;

    logic                 vc_reg;
    logic [npd_pkg::BEST_W-1:0] sq_reg;

    // stage a: absolute differences
    always_comb
    begin
        diff_x = $signed({qx[COORD_WIDTH-1], qx}) - $signed({px[COORD_WIDTH-1], px});
        diff_y = $signed({qy[COORD_WIDTH-1], qy}) - $signed({py[COORD_WIDTH-1], py});
        abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
        abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    end

    // stage b: squares of the low bits, anything larger saturates
    always_comb
    begin
        dx_ext   = EXT_W'(dx_reg);
        dy_ext   = EXT_W'(dy_reg);
        ovf_next = (|dx_ext[EXT_W-1:npd_pkg::LIM_W]) | (|dy_ext[EXT_W-1:npd_pkg::LIM_W]);
        sqx_next = PW'(dx_ext[npd_pkg::LIM_W-1:0]) * PW'(dx_ext[npd_pkg::LIM_W-1:0]);
        sqy_next = PW'(dy_ext[npd_pkg::LIM_W-1:0]) * PW'(dy_ext[npd_pkg::LIM_W-1:0]);
    end

    // stage c: sum with clamp
    always_comb
    begin
        sum = (PW + 1)'(sqx_reg) + (PW + 1)'(sqy_reg);
        if (ovf_reg || sum[PW])
        begin
            sq_next = '1;
        end
        else
        begin
            sq_next = sum[npd_pkg::BEST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= abs_x;
        dy_reg  <= abs_y;
        ovf_reg <= ovf_next;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        sq_reg  <= sq_next;
    end

    assign busy      = va_reg | vb_reg | vc_reg;
    assign out_valid = vc_reg;
    assign out_sq    = sq_reg;

endmodule

// File: design/npd_sqrt_cell.sv
// one digit step of the integer square root chain
module npd_sqrt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  npd_pkg::sqrt_stage_t stage_in,
    output npd_pkg::sqrt_stage_t stage_out
);

    logic [npd_pkg::REM_W-1:0]  rem_sh;
    logic [npd_pkg::REM_W-1:0]  trial;
    logic                       take;

    logic                       valid_reg;
    logic [npd_pkg::RAD_W-1:0]  rad_reg;
    logic [npd_pkg::REM_W-1:0]  rem_reg;
    logic [npd_pkg::ROOT_W-1:0] root_reg;

    always_comb
    begin
        rem_sh = {stage_in.rem[npd_pkg::REM_W-3:0],
                  stage_in.rad[npd_pkg::RAD_W-1:npd_pkg::RAD_W-2]};
        trial  = npd_pkg::REM_W'({stage_in.root, 2'b01});
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= {stage_in.rad[npd_pkg::RAD_W-3:0], 2'b00};
        rem_reg  <= take ? (rem_sh - trial) : rem_sh;
        root_reg <= {stage_in.root[npd_pkg::ROOT_W-2:0], take};
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.rad   = rad_reg;
    assign stage_out.rem   = rem_reg;
    assign stage_out.root  = root_reg;

endmodule

// File: bench/tb_nearest_point_distance.sv
// testbench for the nearest point distance block: directed table, random loads and queries
module tb_nearest_point_distance;

    localparam int TABLE_DEPTH = 1024;
    localparam int S_W = ((npd_pkg::INDEX_W + 32 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 480;
    localparam int TAIL_ITEMS = 60;
    localparam logic [npd_pkg::APB_ADDR_W-1:0] ADDR_POINT_COUNT =
        npd_pkg::APB_ADDR_W'(npd_pkg::REG_POINT_COUNT) << 2;

    typedef struct packed {
        logic [npd_pkg::DIST_W-1:0] distance;
        logic [npd_pkg::SQ_W-1:0]   sq;
        logic                       empty;
    } answer_t;

    typedef struct {
        bit                        set_cfg;
        bit [npd_pkg::COUNT_W-1:0] cfg;
        logic                      mode;
        bit [npd_pkg::INDEX_W-1:0] idx;
        bit [15:0]                 x;
        bit [15:0]                 y;
        bit                        typed;
        answer_t                   want;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [npd_pkg::APB_ADDR_W-1:0]    paddr = '0;
    logic [npd_pkg::APB_DATA_W-1:0]    pwdata = '0;
    logic [npd_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // fields from bit 0: point_index, coord_x, coord_y
    logic [S_W-1:0]                    s_tdata = '0;
    // fields from bit 0: mode
    logic                              s_tuser = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b1;
    // fields from bit 0: nearest_distance, nearest_squared
    logic [55:0]                       m_tdata;
    // fields from bit 0: table_empty
    logic                              m_tuser;

    logic [15:0]                       shape_x [TABLE_DEPTH];
    logic [15:0]                       shape_y [TABLE_DEPTH];
    bit                                loaded [TABLE_DEPTH];
    int                                loaded_prefix = 0;
    logic [npd_pkg::COUNT_W-1:0]       count_setting = '0;
    answer_t                           pending_answers [$];
    stim_row_t                         dir_rows [$];
    bit                                idle_on = 1'b0;
    int                                stall_left = 0;
    int                                errors = 0;
    int                                items = 0;
    int                                queries = 0;
    int                                results = 0;
    int                                cycles = 0;

    nearest_point_distance dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycles, pending_answers.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (errors < 50)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    function automatic answer_t nearest_from_table(input logic [15:0] qx, input logic [15:0] qy);
        answer_t a;
        int      n;
        longint  best;
        longint  dx;
        longint  dy;
        longint  d2;
        longint  root;
        longint  trial;
        a = '0;
        n = (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
        if (n == 0)
        begin
            a.empty = 1'b1;
            return a;
        end
        best = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < n; i++)
        begin
            dx = longint'($signed(qx)) - longint'($signed(shape_x[i]));
            dy = longint'($signed(qy)) - longint'($signed(shape_y[i]));
            d2 = dx * dx + dy * dy;
            if (d2 < best)
                best = d2;
        end
        // integer root, one bit at a time from the top
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= best)
                root = trial;
        end
        a.distance = npd_pkg::DIST_W'(root);
        a.sq = npd_pkg::SQ_W'(best);
        return a;
    endfunction

    task automatic add_row(input bit set_cfg, input bit [npd_pkg::COUNT_W-1:0] cfg,
                           input logic mode, input bit [npd_pkg::INDEX_W-1:0] idx,
                           input bit [15:0] x, input bit [15:0] y, input bit typed,
                           input bit [npd_pkg::DIST_W-1:0] distance,
                           input bit [npd_pkg::SQ_W-1:0] sq, input bit empty);
        stim_row_t r;
        r.set_cfg = set_cfg;
        r.cfg = cfg;
        r.mode = mode;
        r.idx = idx;
        r.x = x;
        r.y = y;
        r.typed = typed;
        r.want.distance = distance;
        r.want.sq = sq;
        r.want.empty = empty;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic send_item(input logic mode, input logic [npd_pkg::INDEX_W-1:0] idx,
                             input logic [15:0] x, input logic [15:0] y,
                             input bit typed, input answer_t want);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {{(S_W - npd_pkg::INDEX_W - 32){1'b0}}, y, x, idx};
        do @(posedge clk); while (!s_tready);
        items++;
        if (mode == npd_pkg::MODE_LOAD)
        begin
            shape_x[idx] = x;
            shape_y[idx] = y;
            loaded[idx] = 1'b1;
            while (loaded_prefix < TABLE_DEPTH && loaded[loaded_prefix])
                loaded_prefix++;
        end
        else
        begin
            queries++;
            pending_answers.insert(pending_answers.size(),
                                   typed ? want : nearest_from_table(x, y));
        end
    endtask

    task automatic send_random_item();
        logic                        mode;
        logic [npd_pkg::INDEX_W-1:0] idx;
        logic [15:0]                 x;
        logic [15:0]                 y;
        int                          pick;
        idx = npd_pkg::INDEX_W'($urandom);
        if ($urandom_range(0, 99) < 55)
        begin
            mode = npd_pkg::MODE_QUERY;
            if (count_setting != 0 && $urandom_range(0, 9) < 6)
            begin
                pick = $urandom_range(0, int'(count_setting) - 1);
                x = shape_x[pick] + 16'($urandom_range(0, 64)) - 16'd32;
                y = shape_y[pick] + 16'($urandom_range(0, 64)) - 16'd32;
            end
            else
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
        end
        else
        begin
            mode = npd_pkg::MODE_LOAD;
            pick = $urandom_range(0, 9);
            if (pick < 5 && loaded_prefix < TABLE_DEPTH)
                idx = npd_pkg::INDEX_W'(loaded_prefix);
            else if (pick < 8 && loaded_prefix > 0)
                idx = npd_pkg::INDEX_W'($urandom_range(0, loaded_prefix - 1));
            if ($urandom_range(0, 9) < 3)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else
            begin
                x = 16'($urandom_range(0, 4095)) - 16'd2048;
                y = 16'($urandom_range(0, 4095)) - 16'd2048;
            end
        end
        send_item(mode, idx, x, y, 0, '0);
    endtask

    task automatic set_point_count(input logic [npd_pkg::COUNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_POINT_COUNT;
        pwdata <= npd_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== npd_pkg::APB_DATA_W'(value))
            report_mismatch("point_count read back", prdata, value);
        psel <= 1'b0;
        penable <= 1'b0;
        count_setting = value;
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results++;
            if (pending_answers.size() == 0)
                report_mismatch("result with nothing expected, distance", m_tdata[16:0], 0);
            else
            begin
                want = pending_answers.pop_front();
                if (m_tdata[16:0] !== want.distance)
                    report_mismatch("nearest_distance", m_tdata[16:0], want.distance);
                if (m_tdata[49:17] !== want.sq)
                    report_mismatch("nearest_squared", m_tdata[49:17], want.sq);
                if (m_tuser !== want.empty)
                    report_mismatch("table_empty", m_tuser, want.empty);
            end
        end
    end

    initial
    begin
        int rand_items;
        int epoch_len;
        int hi;

        // empty table, extremes, exact hits, rounding of the root
        add_row(0, 0, npd_pkg::MODE_QUERY, 0, 16'h0000, 16'h0000, 1, 0, 0, 1);
        add_row(0, 0, npd_pkg::MODE_QUERY, 1023, 16'h8000, 16'h7FFF, 1, 0, 0, 1);
        add_row(0, 0, npd_pkg::MODE_QUERY, 512, 16'h7FFF, 16'h8000, 1, 0, 0, 1);
        add_row(0, 0, npd_pkg::MODE_LOAD, 0, 16'h8000, 16'h8000, 0, 0, 0, 0);
        add_row(0, 0, npd_pkg::MODE_LOAD, 1023, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0);
        add_row(1, 1, npd_pkg::MODE_QUERY, 0, 16'h8000, 16'h8000, 1, 0, 0, 0);
        add_row(0, 0, npd_pkg::MODE_QUERY, 1023, 16'h7FFF, 16'h7FFF, 1,
                17'd92680, 33'd8589672450, 0);
        add_row(0, 0, npd_pkg::MODE_LOAD, 1, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0);
        add_row(1, 2, npd_pkg::MODE_QUERY, 0, 16'h0000, 16'h0000, 0, 0, 0, 0);
        add_row(0, 0, npd_pkg::MODE_QUERY, 77, 16'h7FFF, 16'h8000, 0, 0, 0, 0);
        add_row(0, 0, npd_pkg::MODE_LOAD, 2, 16'h0005, 16'h0005, 0, 0, 0, 0);
        add_row(1, 3, npd_pkg::MODE_QUERY, 1023, 16'h0008, 16'h0009, 1, 5, 25, 0);
        add_row(0, 0, npd_pkg::MODE_QUERY, 0, 16'h0007, 16'h0007, 1, 2, 8, 0);
        add_row(0, 0, npd_pkg::MODE_QUERY, 3, 16'h0005, 16'h0005, 1, 0, 0, 0);
        add_row(0, 0, npd_pkg::MODE_QUERY, 341, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
        add_row(0, 0, npd_pkg::MODE_QUERY, 682, 16'h0100, 16'hFF00, 0, 0, 0, 0);
        add_row(1, 0, npd_pkg::MODE_QUERY, 0, 16'h0064, 16'hFF9C, 1, 0, 0, 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].set_cfg)
                set_point_count(dir_rows[k].cfg);
            send_item(dir_rows[k].mode, dir_rows[k].idx, dir_rows[k].x, dir_rows[k].y,
                      dir_rows[k].typed, dir_rows[k].want);
        end

        // random phase: each epoch sets a count inside the loaded prefix
        idle_on = 1'b1;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            hi = (loaded_prefix < 96) ? loaded_prefix : 96;
            if (hi == 0 || $urandom_range(0, 7) == 0)
                set_point_count(0);
            else if ($urandom_range(0, 5) == 0)
                set_point_count(npd_pkg::COUNT_W'(hi));
            else
                set_point_count(npd_pkg::COUNT_W'($urandom_range(1, hi)));
            epoch_len = $urandom_range(20, 60);
            repeat (epoch_len)
            begin
                send_random_item();
                rand_items++;
            end
        end

        // last part without idling, at the loaded prefix capped at 96 points
        idle_on = 1'b0;
        hi = (loaded_prefix < 96) ? loaded_prefix : 96;
        set_point_count(npd_pkg::COUNT_W'(hi));
        repeat (TAIL_ITEMS) send_random_item();

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("ran %0d items, %0d of them queries, %0d results checked", items, queries,
                 results);
        $display("point counts from an empty table up to 96 loaded points, %0d cycles",
                 cycles);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
